// ----- sv/glra_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package glra_pkg;

   localparam int MAX_REGRESSORS = 6;
   localparam int CSR_ADDR_W     = 5;
   localparam int CSR_DATA_W     = 32;

   // Register indexes on the configuration port (byte address is four times the index).
   localparam logic [2:0] REG_BETA_0 = 3'd0;
   localparam logic [2:0] REG_BETA_1 = 3'd1;
   localparam logic [2:0] REG_BETA_2 = 3'd2;
   localparam logic [2:0] REG_BETA_3 = 3'd3;
   localparam logic [2:0] REG_BETA_4 = 3'd4;
   localparam logic [2:0] REG_BETA_5 = 3'd5;
   localparam logic [2:0] REG_ACTIVE = 3'd6;

   typedef struct packed {
      logic signed [15:0] sample_y;
      logic signed [15:0] design_x0;
      logic signed [15:0] design_x1;
      logic signed [15:0] design_x2;
      logic signed [15:0] design_x3;
      logic signed [15:0] design_x4;
      logic signed [15:0] design_x5;
      logic               last_sample;
   } req_type;

   typedef struct packed {
      logic signed [31:0] residual;
      logic signed [15:0] lag1_corr;
      logic               corr_valid;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAC,
      ST_ROUND,
      ST_CROSS,
      ST_ENERGY,
      ST_EACC,
      ST_DIVSET,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ----- sv/glm_residual_lag1_autocorr.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Residual and lag-1 autocorrelation engine for one time course.
// Each request carries a sample y and its design row x0..x5; it produces one
// response with the residual y - sum(x_j*beta_j) in Q16.16. The response of the
// request marked last_sample also carries the lag-1 coefficient in Q1.15 with
// corr_valid set, and the running sums then clear for the next time course.
// The user must write the betas and the active regressor count on the csr_ port only
// while idle; the block does not enforce this. One request is processed at a time;
// req_stall is high from acceptance until its response has been loaded into the
// output register. All products go through one 32x32 multiplier: the design row in
// ST_MAC, then the residual rounding and the cross and energy products and sums, then
// the response load in ST_DONE; a last request adds a divider setup step and, unless
// the energy sum is zero or the coefficient saturates, the one-bit-per-cycle
// divider. The response register holds while rsp_stall is high and the engine waits
// in its final step until it is free; a new request can be accepted while the
// previous response is still waiting. Synchronous reset clears the sums, sets
// active_regressors to 1 and the betas to zero, and empties the response register.
module glm_residual_lag1_autocorr
   import glra_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire req_type               req_data,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      rsp_type               rsp_data,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready
);

   localparam int ACC_W = 52;

   state_type state_ff, state_in;

   logic signed [31:0] beta_0_ff, beta_1_ff, beta_2_ff, beta_3_ff, beta_4_ff, beta_5_ff;
   logic [2:0]         active_ff;

   req_type            req_ff;
   logic [2:0]         step_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [31:0] e_ff, e_in;
   logic signed [31:0] prev_ff;
   logic signed [63:0] cross_ff, energy_ff;
   logic               first_ff;

   logic [63:0]        mag_ff, den_ff;
   logic [14:0]        quo_ff;
   logic               neg_ff;
   logic [3:0]         div_cnt_ff;
   logic signed [15:0] corr_ff;

   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic               req_accept;
   logic               rsp_load;
   logic               csr_write;
   logic [2:0]         csr_index;

   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_p;
   logic               mul_use;
   logic signed [15:0] x_sel;
   logic signed [31:0] beta_sel;

   logic signed [ACC_W-1:0] acc_rnd;
   logic [63:0]        mag_sh;
   logic signed [63:0] neg_energy;

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s[64] != s[63]) begin
         sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         sat_add64 = s[63:0];
      end
   endfunction

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_0_ff <= '0;
         beta_1_ff <= '0;
         beta_2_ff <= '0;
         beta_3_ff <= '0;
         beta_4_ff <= '0;
         beta_5_ff <= '0;
         active_ff <= 3'd1;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_BETA_0: beta_0_ff <= csr_pwdata;
            REG_BETA_1: beta_1_ff <= csr_pwdata;
            REG_BETA_2: beta_2_ff <= csr_pwdata;
            REG_BETA_3: beta_3_ff <= csr_pwdata;
            REG_BETA_4: beta_4_ff <= csr_pwdata;
            REG_BETA_5: beta_5_ff <= csr_pwdata;
            REG_ACTIVE: active_ff <= csr_pwdata[2:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_BETA_0: csr_prdata = beta_0_ff;
         REG_BETA_1: csr_prdata = beta_1_ff;
         REG_BETA_2: csr_prdata = beta_2_ff;
         REG_BETA_3: csr_prdata = beta_3_ff;
         REG_BETA_4: csr_prdata = beta_4_ff;
         REG_BETA_5: csr_prdata = beta_5_ff;
         REG_ACTIVE: csr_prdata = {29'd0, active_ff};
         default:    csr_prdata = '0;
      endcase
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_MAC;
         ST_MAC:    if (step_ff == 3'(MAX_REGRESSORS)) state_in = ST_ROUND;
         ST_ROUND:  state_in = ST_CROSS;
         ST_CROSS:  state_in = ST_ENERGY;
         ST_ENERGY: state_in = ST_EACC;
         ST_EACC:   state_in = req_ff.last_sample ? ST_DIVSET : ST_DONE;
         ST_DIVSET: state_in = (energy_ff == '0 || cross_ff >= energy_ff ||
                                cross_ff <= neg_energy) ? ST_DONE : ST_DIV;
         ST_DIV:    if (div_cnt_ff == 4'd14) state_in = ST_DONE;
         ST_DONE:   if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      req_accept = req_valid && !req_stall;
      rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- shared multiplier ----------------
   always_comb begin
      case (step_ff)
         3'd0:    begin x_sel = req_ff.design_x0; beta_sel = beta_0_ff; end
         3'd1:    begin x_sel = req_ff.design_x1; beta_sel = beta_1_ff; end
         3'd2:    begin x_sel = req_ff.design_x2; beta_sel = beta_2_ff; end
         3'd3:    begin x_sel = req_ff.design_x3; beta_sel = beta_3_ff; end
         3'd4:    begin x_sel = req_ff.design_x4; beta_sel = beta_4_ff; end
         3'd5:    begin x_sel = req_ff.design_x5; beta_sel = beta_5_ff; end
         default: begin x_sel = '0;               beta_sel = '0;        end
      endcase

      mul_use = 1'b1;
      case (state_ff)
         ST_MAC: begin
            mul_a   = 32'(x_sel);
            mul_b   = beta_sel;
            mul_use = (step_ff < active_ff) && (step_ff < 3'(MAX_REGRESSORS));
         end
         ST_CROSS: begin
            mul_a = e_ff;
            mul_b = prev_ff;
         end
         default: begin
            mul_a = e_ff;
            mul_b = e_ff;
         end
      endcase
      mul_p   = mul_a * mul_b;
      prod_in = mul_use ? mul_p : '0;
   end

   // Residual rounding: Q.30 sum plus half an LSB of Q.16, then an arithmetic shift by 14.
   always_comb begin
      acc_rnd = acc_ff + ACC_W'(15'sd8192);
      if (!acc_rnd[ACC_W-1] && (acc_rnd[ACC_W-2:45] != '0)) begin
         e_in = {1'b0, {31{1'b1}}};
      end else if (acc_rnd[ACC_W-1] && (acc_rnd[ACC_W-2:45] != '1)) begin
         e_in = {1'b1, 31'd0};
      end else begin
         e_in = acc_rnd[45:14];
      end
      neg_energy = -energy_ff;
      mag_sh     = {mag_ff[62:0], 1'b0};
   end

   // ---------------- datapath ----------------
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff  <= req_data;
         step_ff <= '0;
         acc_ff  <= {{(ACC_W-46){req_data.sample_y[15]}}, req_data.sample_y, 30'd0};
      end

      unique case (state_ff)
         ST_MAC: begin
            prod_ff <= prod_in;
            if (step_ff != '0) begin
               acc_ff <= acc_ff - prod_ff[ACC_W-1:0];
            end
            step_ff <= step_ff + 3'd1;
         end
         ST_ROUND: e_ff <= e_in;
         ST_CROSS: prod_ff <= prod_in;
         ST_ENERGY: prod_ff <= prod_in;
         ST_DIVSET: begin
            quo_ff     <= '0;
            div_cnt_ff <= '0;
            neg_ff     <= cross_ff[63];
            mag_ff     <= cross_ff[63] ? 64'(-cross_ff) : 64'(cross_ff);
            den_ff     <= 64'(energy_ff);
            if (energy_ff == '0) begin
               corr_ff <= '0;
            end else if (cross_ff >= energy_ff) begin
               corr_ff <= 16'sh7FFF;
            end else if (cross_ff <= neg_energy) begin
               corr_ff <= 16'sh8000;
            end
         end
         ST_DIV: begin
            if (mag_sh >= den_ff) begin
               mag_ff <= mag_sh - den_ff;
               quo_ff <= {quo_ff[13:0], 1'b1};
            end else begin
               mag_ff <= mag_sh;
               quo_ff <= {quo_ff[13:0], 1'b0};
            end
            div_cnt_ff <= div_cnt_ff + 4'd1;
            if (div_cnt_ff == 4'd14) begin
               if (mag_sh >= den_ff) begin
                  corr_ff <= neg_ff ? -$signed({1'b0, quo_ff[13:0], 1'b1})
                                    : $signed({1'b0, quo_ff[13:0], 1'b1});
               end else begin
                  corr_ff <= neg_ff ? -$signed({1'b0, quo_ff[13:0], 1'b0})
                                    : $signed({1'b0, quo_ff[13:0], 1'b0});
               end
            end
         end
         default: ;
      endcase

      if (rsp_load) begin
         rsp_data_ff.residual   <= e_ff;
         rsp_data_ff.lag1_corr  <= req_ff.last_sample ? corr_ff : '0;
         rsp_data_ff.corr_valid <= req_ff.last_sample;
      end
   end

   // Running sums; cleared at reset and after the last sample of a course.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         cross_ff  <= '0;
         energy_ff <= '0;
         first_ff  <= 1'b1;
      end else begin
         if (state_ff == ST_ENERGY && !first_ff) begin
            cross_ff <= sat_add64(cross_ff, prod_ff);
         end
         if (state_ff == ST_EACC) begin
            energy_ff <= sat_add64(energy_ff, prod_ff);
            prev_ff   <= e_ff;
            first_ff  <= 1'b0;
         end
         if (rsp_load && req_ff.last_sample) begin
            prev_ff   <= '0;
            cross_ff  <= '0;
            energy_ff <= '0;
            first_ff  <= 1'b1;
         end
      end
   end

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- sv/glra_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module glra_checker
   import glra_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // One request at a time: the engine is busy right after taking one.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while the engine was still busy");

   // A response cannot appear in the cycle right after a request is taken.
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("response appeared too early after a request");

   a_corr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.corr_valid |-> rsp_data.lag1_corr == 16'sd0)
      else $error("coefficient nonzero on a response that is not last");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind glm_residual_lag1_autocorr glra_checker u_glra_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ----- tb/glm_residual_lag1_autocorr_tb.sv -----
`timescale 1ns / 1ps

module glm_residual_lag1_autocorr_tb;
   import glra_pkg::*;

   localparam logic [2:0] REG_UNUSED     = 3'd7;
   localparam int         SETTLE_CYCLES  = 40;
   localparam int         WATCHDOG_LIMIT = 5000;
   localparam int         HOLD_CYCLES    = 300;
   localparam int         SEGMENT_ITEMS  = 60;

   // Predicts the residual response of each accepted request and checks the DUT against it.
   class residual_scoreboard;
      logic signed [31:0] beta [6];
      logic [2:0]         active_cols;
      longint             prev_e;
      longint             cross_acc;
      longint             energy_acc;
      bit                 course_start;
      rsp_type            pending_residuals [$];
      int                 errors;

      function new();
         for (int j = 0; j < 6; j++) beta[j] = '0;
         active_cols  = 3'd1;
         prev_e       = 0;
         cross_acc    = 0;
         energy_acc   = 0;
         course_start = 1'b1;
         errors       = 0;
      endfunction

      function void write_register(logic [2:0] idx, logic [31:0] value);
         if (idx <= REG_BETA_5) begin
            beta[idx] = value;
         end else if (idx == REG_ACTIVE) begin
            active_cols = value[2:0];
         end
      endfunction

      function longint sat_add64(longint a, longint b);
         longint s;
         s = a + b;
         if (a >= 0 && b >= 0 && s < 0) return 64'sh7FFF_FFFF_FFFF_FFFF;
         if (a < 0 && b < 0 && s >= 0) return 64'sh8000_0000_0000_0000;
         return s;
      endfunction

      function logic signed [15:0] lag1_coef(longint c, longint en);
         logic [79:0]        num;
         logic [79:0]        quo;
         logic [63:0]        mag;
         logic signed [15:0] q16;
         if (en <= 0) return '0;
         if (c >= en) return 16'sd32767;
         if (c <= -en) return -16'sd32768;
         mag = (c < 0) ? -c : c;
         num = {16'd0, mag} << 15;
         quo = num / {16'd0, en};
         q16 = quo[15:0];
         return (c < 0) ? -q16 : q16;
      endfunction

      function rsp_type compute_residual_step(req_type r);
         logic signed [15:0] xs [6];
         longint             acc;
         longint             e;
         rsp_type            res;
         xs[0] = r.design_x0;
         xs[1] = r.design_x1;
         xs[2] = r.design_x2;
         xs[3] = r.design_x3;
         xs[4] = r.design_x4;
         xs[5] = r.design_x5;
         acc = longint'(r.sample_y) * (longint'(1) << 30);
         for (int j = 0; j < MAX_REGRESSORS; j++) begin
            if (j < int'(active_cols)) acc -= longint'(xs[j]) * longint'(beta[j]);
         end
         e = (acc + (longint'(1) << 13)) >>> 14;
         if (e > 64'sd2147483647) e = 64'sd2147483647;
         if (e < -64'sd2147483648) e = -64'sd2147483648;
         if (!course_start) cross_acc = sat_add64(cross_acc, e * prev_e);
         energy_acc   = sat_add64(energy_acc, e * e);
         prev_e       = e;
         course_start = 1'b0;
         res.residual   = e[31:0];
         res.lag1_corr  = '0;
         res.corr_valid = r.last_sample;
         if (r.last_sample) begin
            res.lag1_corr = lag1_coef(cross_acc, energy_acc);
            prev_e        = 0;
            cross_acc     = 0;
            energy_acc    = 0;
            course_start  = 1'b1;
         end
         return res;
      endfunction

      function void note_request(req_type r);
         pending_residuals.push_back(compute_residual_step(r));
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_residuals.size() == 0) begin
            errors++;
            if (errors <= 10) $display("response with none pending: residual %0d corr %0d/%0b",
                                       got.residual, got.lag1_corr, got.corr_valid);
            return;
         end
         want = pending_residuals.pop_front();
         if (got.residual !== want.residual || got.lag1_corr !== want.lag1_corr ||
             got.corr_valid !== want.corr_valid) begin
            errors++;
            if (errors <= 10)
               $display("mismatch at %0t: residual %0d/%0d corr %0d/%0d valid %0b/%0b (exp/act)",
                        $realtime, want.residual, got.residual, want.lag1_corr, got.lag1_corr,
                        want.corr_valid, got.corr_valid);
         end
      endfunction

      function int outstanding();
         return pending_residuals.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic                  hold_off       = 1'b0;
   int                    send_idle_pct  = 0;
   int                    recv_stall_pct = 0;
   int                    quiet_cycles   = 0;
   residual_scoreboard    sb;

   glm_residual_lag1_autocorr DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= hold_off || ($urandom_range(0, 99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.write_register(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic offer_request(input req_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // The extra edge lets the monitor record a request accepted at the current edge.
   task automatic drain_block(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic hold_receiver(input int cycles);
      hold_off <= 1'b1;
      repeat (cycles) @(posedge clock);
      hold_off <= 1'b0;
   endtask

   function automatic req_type make_req(int y, int x0, int x1, int x2, int x3, int x4, int x5,
                                        bit last);
      req_type r;
      r.sample_y    = 16'(y);
      r.design_x0   = 16'(x0);
      r.design_x1   = 16'(x1);
      r.design_x2   = 16'(x2);
      r.design_x3   = 16'(x3);
      r.design_x4   = 16'(x4);
      r.design_x5   = 16'(x5);
      r.last_sample = last;
      return r;
   endfunction

   function automatic int rand_x(int mode);
      int v;
      case (mode)
         0: v = $urandom_range(0, 65535) - 32768;
         1: v = $urandom_range(0, 32768) - 16384;
         default: v = ($urandom_range(0, 1) != 0) ? 16384 : 0;
      endcase
      return v;
   endfunction

   function automatic int rand_beta(bit wide);
      int v;
      if (wide || $urandom_range(0, 7) == 0) v = $urandom;
      else v = $urandom_range(0, 2097152) - 1048576;
      return v;
   endfunction

   task automatic load_config(input bit wide);
      int       pick;
      logic [2:0] cols;
      for (int i = 0; i < MAX_REGRESSORS; i++) csr_write(REG_BETA_0 + 3'(i), rand_beta(wide));
      pick = $urandom_range(0, 9);
      if (pick < 8) cols = 3'($urandom_range(1, 6));
      else if (pick == 8) cols = 3'd0;
      else cols = 3'd7;
      csr_write(REG_ACTIVE, ($urandom & 32'hFFFF_FFF8) | 32'(cols));
      if ($urandom_range(0, 3) == 0) csr_write(REG_UNUSED, $urandom);
   endtask

   function automatic int clamp16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // Mostly short courses; the sample shape varies so the coefficient spans its range.
   task automatic run_courses(input int count, input bit pause_midway);
      int sent;
      int len;
      int y_mode;
      int x_mode;
      int y;
      bit paused;
      sent   = 0;
      paused = 1'b0;
      while (sent < count) begin
         len    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
         y_mode = $urandom_range(0, 2);
         x_mode = $urandom_range(0, 2);
         y      = $urandom_range(0, 65535) - 32768;
         for (int k = 0; k < len; k++) begin
            case (y_mode)
               0: y = $urandom_range(0, 65535) - 32768;
               1: y = clamp16(y + $urandom_range(0, 400) - 200);
               default: y = clamp16(-y + $urandom_range(0, 20) - 10);
            endcase
            offer_request(make_req(y, rand_x(x_mode), rand_x(x_mode), rand_x(x_mode),
                                   rand_x(x_mode), rand_x(x_mode), rand_x(x_mode), k == len - 1));
            sent++;
         end
         if (pause_midway && !paused && sent >= count / 2) begin
            paused = 1'b1;
            drain_block(0);
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset weights: residual is the sample itself; a lone zero sample has no energy.
      offer_request(make_req(0, 12345, -1, 0, 0, 0, 0, 1'b1));
      offer_request(make_req(32767, -32768, 32767, 0, 0, 0, 0, 1'b0));
      offer_request(make_req(-32768, 32767, -32768, 0, 0, 0, 0, 1'b1));
      offer_request(make_req(100, 0, 0, 0, 0, 0, 0, 1'b0));
      offer_request(make_req(90, 0, 0, 0, 0, 0, 0, 1'b1));
      drain_block(SETTLE_CYCLES);

      csr_write(REG_BETA_0, 32'h7FFF_FFFF);
      csr_write(REG_BETA_1, 32'h8000_0000);
      for (int i = 2; i < MAX_REGRESSORS; i++) csr_write(REG_BETA_0 + 3'(i), rand_beta(1'b1));
      csr_write(REG_ACTIVE, 32'd6);
      csr_write(REG_UNUSED, 32'hFFFF_FFFF);
      // Residual pinned at the negative limit drives both sums into saturation.
      repeat (2) offer_request(make_req(-32768, 32767, 0, 0, 0, 0, 0, 1'b0));
      offer_request(make_req(-32768, 32767, 0, 0, 0, 0, 0, 1'b1));
      // Alternating limits give a cross sum saturated negative.
      for (int k = 0; k < 4; k++) begin
         if (k % 2 == 0) offer_request(make_req(-32768, 32767, 0, 0, 0, 0, 0, 1'b0));
         else offer_request(make_req(32767, -32768, 0, 0, 0, 0, 0, k == 3));
      end
      offer_request(make_req(32767, 32767, 32767, 32767, 32767, 32767, 32767, 1'b1));
      offer_request(make_req(-32768, -32768, -32768, -32768, -32768, -32768, -32768, 1'b1));
      offer_request(make_req(0, 0, 32767, 0, 0, 0, 0, 1'b1));
      drain_block(SETTLE_CYCLES);

      // A count of zero removes every column; seven behaves as all six.
      for (int i = 0; i < MAX_REGRESSORS; i++) csr_write(REG_BETA_0 + 3'(i), rand_beta(1'b0));
      csr_write(REG_ACTIVE, 32'd0);
      for (int k = 0; k < 3; k++)
         offer_request(make_req($urandom_range(0, 65535) - 32768, rand_x(0), rand_x(0), rand_x(0),
                                rand_x(0), rand_x(0), rand_x(0), k == 2));
      drain_block(SETTLE_CYCLES);
      csr_write(REG_ACTIVE, 32'hFFFF_FFFF);
      for (int k = 0; k < 3; k++)
         offer_request(make_req($urandom_range(0, 65535) - 32768, rand_x(0), rand_x(0), rand_x(0),
                                rand_x(0), rand_x(0), rand_x(0), k == 2));
      drain_block(SETTLE_CYCLES);

      for (int seg = 0; seg < 8; seg++) begin
         case (seg / 2)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
         endcase
         load_config(seg == 7);
         if (seg == 0) fork
            hold_receiver(HOLD_CYCLES);
         join_none
         run_courses(SEGMENT_ITEMS, seg == 3);
         drain_block(SETTLE_CYCLES);
      end

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      drain_block(SETTLE_CYCLES);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/glra_pkg.sv
sv/glm_residual_lag1_autocorr.sv
sv/glra_checker.sv
tb/glm_residual_lag1_autocorr_tb.sv
